// File: design/vrt_pkg.sv
`default_nettype none
package vrt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIST_W        = 40;
    localparam int CELL_W        = 24;
    localparam int DIR_W         = 16;
    localparam int MAXD_W        = 16;
    localparam logic [MAXD_W-1:0] MAXD_RESET = 16'd1280;
    localparam logic [DIST_W-1:0] DIST_NEVER = {DIST_W{1'b1}};

    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_ANSWER = 1'b1;

    localparam logic [1:0] ANS_AIR     = 2'd0;
    localparam logic [1:0] ANS_SOLID   = 2'd1;
    localparam logic [1:0] ANS_MISSING = 2'd2;

    typedef enum logic [1:0] {
        OUT_QUERY,
        OUT_HIT,
        OUT_MISS
    } out_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_CHECK,
        ST_STEP,
        ST_ESUB,
        ST_REACH,
        ST_EMIT_Q,
        ST_WAIT,
        ST_EMIT_HIT,
        ST_EMIT_MISS
    } state_t;

    typedef struct packed {
        logic      load;
        logic      div_start;
        logic      div_wb;
        logic [2:0] job;
        logic      init_walk;
        logic      do_step;
        logic      esub;
        logic      inc_count;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic cap_reached;
        logic cell_nonneg;
        logic reach_pass;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// File: design/voxel_ray_traversal_unit.sv
// channel | direction | handshake           | payload
// s_      | in        | s_valid / s_ready   | req_type, origin_x/y/z, dir_x/y/z, voxel_answer
// m_      | out       | m_valid / m_ready   | result_kind, voxel_x/y/z, is_hit, normal_x/y/z
// cfg_    | in        | cfg_valid/cfg_ready | cfg_data = max_distance (cfg_ready always high)
// a start runs 6 serial divisions
// each voxel step runs check, axis select, crossing subtract and reach compare in turn
// an air answer steps the ray through step, crossing subtract, reach compare and check before the next query or a miss
// synchronous active-low reset; s_ inputs accepted only when idle or waiting for an answer
// a pending result stalls the controller only when a new result is ready to go out
`default_nettype none
module voxel_ray_traversal_unit #(
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_req_type,
    input  wire logic signed [vrt_pkg::DIST_W-1:0]  s_origin_x,
    input  wire logic signed [vrt_pkg::DIST_W-1:0]  s_origin_y,
    input  wire logic signed [vrt_pkg::DIST_W-1:0]  s_origin_z,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]   s_dir_x,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]   s_dir_y,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]   s_dir_z,
    input  wire logic [1:0]                         s_voxel_answer,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_result_kind,
    output logic signed [vrt_pkg::CELL_W-1:0]       m_voxel_x,
    output logic signed [vrt_pkg::CELL_W-1:0]       m_voxel_y,
    output logic signed [vrt_pkg::CELL_W-1:0]       m_voxel_z,
    output logic                                    m_is_hit,
    output logic signed [1:0]                       m_normal_x,
    output logic signed [1:0]                       m_normal_y,
    output logic signed [1:0]                       m_normal_z,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vrt_pkg::MAXD_W-1:0]         cfg_data
);
    vrt_pkg::cmd_t    cmd;
    vrt_pkg::status_t status;

    assign cfg_ready = 1'b1;

    vrt_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .req_type     (s_req_type),
        .voxel_answer (s_voxel_answer),
        .status       (status),
        .cmd          (cmd)
    );

    vrt_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .origin_x      (s_origin_x),
        .origin_y      (s_origin_y),
        .origin_z      (s_origin_z),
        .dir_x         (s_dir_x),
        .dir_y         (s_dir_y),
        .dir_z         (s_dir_z),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_result_kind (m_result_kind),
        .m_voxel_x     (m_voxel_x),
        .m_voxel_y     (m_voxel_y),
        .m_voxel_z     (m_voxel_z),
        .m_is_hit      (m_is_hit),
        .m_normal_x    (m_normal_x),
        .m_normal_y    (m_normal_y),
        .m_normal_z    (m_normal_z)
    );
endmodule
`default_nettype wire

// File: design/vrt_div.sv
`default_nettype none
module vrt_div #(
    parameter int N = vrt_pkg::FRAC_BITS_DEF + 15
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [N-1:0]           dividend,
    input  wire logic [vrt_pkg::DIR_W-1:0] divisor,
    output logic                        done,
    output logic [N-1:0]                quotient
);
    localparam int CW = $clog2(N + 1);
    localparam int DW = vrt_pkg::DIR_W;

    logic [N-1:0]  quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[N-1]};
        diff      = trial - {1'b0, div_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[N-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(N - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// File: design/vrt_datapath.sv
`default_nettype none
module vrt_datapath #(
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire vrt_pkg::cmd_t                 cmd,
    output vrt_pkg::status_t                   status,
    input  wire logic                          cfg_valid,
    input  wire logic [vrt_pkg::MAXD_W-1:0]    cfg_data,
    input  wire logic signed [vrt_pkg::DIST_W-1:0] origin_x,
    input  wire logic signed [vrt_pkg::DIST_W-1:0] origin_y,
    input  wire logic signed [vrt_pkg::DIST_W-1:0] origin_z,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]  dir_x,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]  dir_y,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]  dir_z,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic                               m_result_kind,
    output logic signed [vrt_pkg::CELL_W-1:0]  m_voxel_x,
    output logic signed [vrt_pkg::CELL_W-1:0]  m_voxel_y,
    output logic signed [vrt_pkg::CELL_W-1:0]  m_voxel_z,
    output logic                               m_is_hit,
    output logic signed [1:0]                  m_normal_x,
    output logic signed [1:0]                  m_normal_y,
    output logic signed [1:0]                  m_normal_z
);
    localparam int DW  = vrt_pkg::DIST_W;
    localparam int CW  = vrt_pkg::CELL_W;
    localparam int RW  = vrt_pkg::DIR_W;
    localparam int MW  = vrt_pkg::MAXD_W;
    localparam int N   = FRAC_BITS + 15;
    localparam int FW  = FRAC_BITS + 1;

    logic [MW-1:0] maxd_reg;
    logic [CW-1:0] cell_reg [3];
    logic          sign_reg [3];
    logic [DW-1:0] cross_reg [3];
    logic [DW-1:0] cstep_reg [3];
    logic [1:0]    norm_reg [3];
    logic [RW-1:0] mag_reg [3];
    logic [FW-1:0] gap_reg [3];
    logic signed [DW:0] e_reg [3];
    logic [15:0]   count_reg;

    logic signed [DW-1:0] org [3];
    logic signed [RW-1:0] dir [3];
    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    logic          div_done;
    logic [N-1:0]  quotient;
    logic [N-1:0]  div_dividend;
    logic [RW-1:0] div_divisor;
    logic [1:0]    job_axis;

    always_comb begin
        job_axis = (cmd.job >= 3'd3) ? 2'(cmd.job - 3'd3) : cmd.job[1:0];
        div_divisor = mag_reg[job_axis];
        if (cmd.job >= 3'd3) begin
            div_dividend = N'(1) << (FRAC_BITS + 14);
        end else begin
            div_dividend = N'(gap_reg[job_axis]) << 14;
        end
    end

    vrt_div #(.N(N)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    logic [1:0]    axis;
    logic [DW:0]   sum;
    logic [DW-1:0] sat;
    always_comb begin
        if (cross_reg[0] < cross_reg[1] && cross_reg[0] < cross_reg[2]) begin
            axis = 2'd0;
        end else if (cross_reg[1] < cross_reg[2]) begin
            axis = 2'd1;
        end else begin
            axis = 2'd2;
        end
        sum = {1'b0, cross_reg[axis]} + {1'b0, cstep_reg[axis]};
        sat = sum[DW] ? vrt_pkg::DIST_NEVER : sum[DW-1:0];
    end

    logic signed [DW:0] best01, best;
    logic signed [DW:0] reach;
    logic [22:0]        cap_prod;
    always_comb begin
        best01 = (e_reg[1] < e_reg[0]) ? e_reg[1] : e_reg[0];
        best   = (e_reg[2] < best01) ? e_reg[2] : best01;
        reach  = (DW+1)'(maxd_reg) << (FRAC_BITS - 8);
        cap_prod = ({7'd0, maxd_reg} << 6) + ({7'd0, maxd_reg} << 5) + ({7'd0, maxd_reg} << 2);
    end

    assign status.div_done    = div_done;
    assign status.cap_reached = count_reg >= {1'b0, cap_prod[22:8]};
    assign status.cell_nonneg = !cell_reg[0][CW-1] && !cell_reg[1][CW-1] && !cell_reg[2][CW-1];
    assign status.reach_pass  = best > reach;
    assign status.out_free    = !m_valid || m_ready;

    logic signed [DW-1:0] flr [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            flr[k] = org[k] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maxd_reg <= vrt_pkg::MAXD_RESET;
            m_valid  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                cell_reg[k]  <= '0;
                sign_reg[k]  <= 1'b0;
                cross_reg[k] <= '0;
                cstep_reg[k] <= '0;
                norm_reg[k]  <= '0;
            end
            count_reg <= '0;
        end else begin
            if (cfg_valid) begin
                maxd_reg <= cfg_data;
            end
            if (cmd.load) begin
                for (int k = 0; k < 3; k++) begin
                    cell_reg[k] <= flr[k][CW-1:0];
                    sign_reg[k] <= (dir[k] > 0);
                    mag_reg[k]  <= dir[k][RW-1] ? RW'(-dir[k]) : dir[k];
                    if (dir[k] > 0) begin
                        gap_reg[k] <= (FW'(1) << FRAC_BITS) - FW'(org[k][FRAC_BITS-1:0]);
                    end else begin
                        gap_reg[k] <= FW'(org[k][FRAC_BITS-1:0]);
                    end
                end
            end
            if (cmd.div_wb) begin
                if (cmd.job >= 3'd3) begin
                    cstep_reg[job_axis] <= (mag_reg[job_axis] == '0) ? vrt_pkg::DIST_NEVER
                                                                    : DW'(quotient);
                end else begin
                    cross_reg[job_axis] <= (mag_reg[job_axis] == '0) ? vrt_pkg::DIST_NEVER
                                                                    : DW'(quotient);
                end
            end
            if (cmd.init_walk) begin
                count_reg <= '0;
                for (int k = 0; k < 3; k++) begin
                    norm_reg[k] <= '0;
                end
            end
            if (cmd.do_step) begin
                cell_reg[axis]  <= cell_reg[axis] + (sign_reg[axis] ? CW'(1) : {CW{1'b1}});
                cross_reg[axis] <= sat;
                for (int k = 0; k < 3; k++) begin
                    if (k == int'(axis)) begin
                        norm_reg[k] <= sign_reg[axis] ? 2'b11 : 2'b01;
                    end else begin
                        norm_reg[k] <= '0;
                    end
                end
            end
            if (cmd.inc_count) begin
                count_reg <= count_reg + 16'd1;
            end
            if (cmd.out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
        if (cmd.esub) begin
            for (int k = 0; k < 3; k++) begin
                e_reg[k] <= (cstep_reg[k] == vrt_pkg::DIST_NEVER)
                          ? $signed({1'b0, vrt_pkg::DIST_NEVER})
                          : $signed({1'b0, cross_reg[k]}) - $signed({1'b0, cstep_reg[k]});
            end
        end
        if (cmd.out_load) begin
            m_result_kind <= (cmd.out_kind != vrt_pkg::OUT_QUERY);
            m_is_hit      <= (cmd.out_kind == vrt_pkg::OUT_HIT);
            if (cmd.out_kind == vrt_pkg::OUT_MISS) begin
                m_voxel_x <= '0;
                m_voxel_y <= '0;
                m_voxel_z <= '0;
            end else begin
                m_voxel_x <= cell_reg[0];
                m_voxel_y <= cell_reg[1];
                m_voxel_z <= cell_reg[2];
            end
            if (cmd.out_kind == vrt_pkg::OUT_HIT) begin
                m_normal_x <= norm_reg[0];
                m_normal_y <= norm_reg[1];
                m_normal_z <= norm_reg[2];
            end else begin
                m_normal_x <= '0;
                m_normal_y <= '0;
                m_normal_z <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// File: design/vrt_ctrl.sv
`default_nettype none
module vrt_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             req_type,
    input  wire logic [1:0]       voxel_answer,
    input  wire vrt_pkg::status_t status,
    output vrt_pkg::cmd_t         cmd
);
    vrt_pkg::state_t state_reg, state_next;
    logic [2:0]      job_reg, job_next;
    logic            acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vrt_pkg::ST_IDLE;
            job_reg   <= '0;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        cmd        = '0;
        cmd.job    = job_reg;
        cmd.out_kind = vrt_pkg::OUT_QUERY;
        s_ready    = (state_reg == vrt_pkg::ST_IDLE) || (state_reg == vrt_pkg::ST_WAIT);
        acc        = s_valid && s_ready;
        unique case (state_reg)
            vrt_pkg::ST_IDLE, vrt_pkg::ST_WAIT: begin
                if (acc && req_type == vrt_pkg::REQ_START) begin
                    cmd.load   = 1'b1;
                    job_next   = '0;
                    state_next = vrt_pkg::ST_DIV_GO;
                end else if (acc && state_reg == vrt_pkg::ST_WAIT) begin
                    if (voxel_answer == vrt_pkg::ANS_AIR) begin
                        state_next = vrt_pkg::ST_STEP;
                    end else if (voxel_answer == vrt_pkg::ANS_SOLID) begin
                        state_next = vrt_pkg::ST_EMIT_HIT;
                    end else begin
                        state_next = vrt_pkg::ST_EMIT_MISS;
                    end
                end
            end
            vrt_pkg::ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = vrt_pkg::ST_DIV_RUN;
            end
            vrt_pkg::ST_DIV_RUN: begin
                if (status.div_done) begin
                    cmd.div_wb = 1'b1;
                    if (job_reg == 3'd5) begin
                        cmd.init_walk = 1'b1;
                        state_next    = vrt_pkg::ST_CHECK;
                    end else begin
                        job_next   = job_reg + 3'd1;
                        state_next = vrt_pkg::ST_DIV_GO;
                    end
                end
            end
            vrt_pkg::ST_CHECK: begin
                if (status.cap_reached) begin
                    state_next = vrt_pkg::ST_EMIT_MISS;
                end else if (status.cell_nonneg) begin
                    state_next = vrt_pkg::ST_EMIT_Q;
                end else begin
                    state_next = vrt_pkg::ST_STEP;
                end
            end
            vrt_pkg::ST_STEP: begin
                cmd.do_step = 1'b1;
                state_next  = vrt_pkg::ST_ESUB;
            end
            vrt_pkg::ST_ESUB: begin
                cmd.esub   = 1'b1;
                state_next = vrt_pkg::ST_REACH;
            end
            vrt_pkg::ST_REACH: begin
                if (status.reach_pass) begin
                    state_next = vrt_pkg::ST_EMIT_MISS;
                end else begin
                    cmd.inc_count = 1'b1;
                    state_next    = vrt_pkg::ST_CHECK;
                end
            end
            vrt_pkg::ST_EMIT_Q: begin
                cmd.out_kind = vrt_pkg::OUT_QUERY;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = vrt_pkg::ST_WAIT;
                end
            end
            vrt_pkg::ST_EMIT_HIT: begin
                cmd.out_kind = vrt_pkg::OUT_HIT;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = vrt_pkg::ST_IDLE;
                end
            end
            vrt_pkg::ST_EMIT_MISS: begin
                cmd.out_kind = vrt_pkg::OUT_MISS;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = vrt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vrt_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: design/vrt_checker.sv
`default_nettype none
module vrt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_result_kind,
    input wire logic [23:0] m_voxel_x,
    input wire logic [23:0] m_voxel_y,
    input wire logic [23:0] m_voxel_z,
    input wire logic        m_is_hit,
    input wire logic [1:0]  m_normal_x,
    input wire logic [1:0]  m_normal_y,
    input wire logic [1:0]  m_normal_z
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_query_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_kind |-> !m_is_hit)
        else $error("query flagged as hit");

    a_nohit_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_hit |-> m_normal_x == 2'd0 && m_normal_y == 2'd0 && m_normal_z == 2'd0)
        else $error("normal without hit");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind && !m_is_hit |->
            m_voxel_x == 24'd0 && m_voxel_y == 24'd0 && m_voxel_z == 24'd0)
        else $error("miss carries a voxel");
endmodule

bind voxel_ray_traversal_unit vrt_checker u_vrt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_voxel_x     (m_voxel_x),
    .m_voxel_y     (m_voxel_y),
    .m_voxel_z     (m_voxel_z),
    .m_is_hit      (m_is_hit),
    .m_normal_x    (m_normal_x),
    .m_normal_y    (m_normal_y),
    .m_normal_z    (m_normal_z)
);
`default_nettype wire
